// ===== rtl/pba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pba_pkg;

  localparam int ID_W   = 12;
  localparam int CNT_W  = ID_W + 1;
  localparam int WORD_W = 64;
  localparam int BIT_W  = 6;

  localparam logic [ID_W-1:0] MIN_PID_RESET = 12'd300;
  localparam logic [ID_W-1:0] MAX_PID_RESET = 12'd3000;

  localparam logic CFG_MIN_PID = 1'b0;
  localparam logic CFG_MAX_PID = 1'b1;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic            mode;
    logic [ID_W-1:0] pid;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] granted_pid;
    logic [1:0]      status;
  } out_item_t;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic rel_read;
    logic rel_write;
    logic scan_first;
    logic scan_next;
    logic scan_commit;
    logic set_full;
    logic set_range;
    logic load_out;
  } pba_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_release;
    logic rel_oor;
    logic range_empty;
    logic found;
    logic chk_last;
    logic out_free;
  } pba_stat_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } ffs_t;

  // Lowest set bit: isolate it with one add, then encode the one-hot word.
  function automatic ffs_t find_first_set(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] low;
    ffs_t              r;
    low     = v & (~v + {{(WORD_W-1){1'b0}}, 1'b1});
    r.found = |v;
    r.idx   = '0;
    for (int k = 0; k < BIT_W; k++) begin
      for (int j = 0; j < WORD_W; j++) begin
        if (((j >> k) & 1) == 1) begin
          r.idx[k] = r.idx[k] | low[j];
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pba_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pba_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pba_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire pba_pkg::pba_stat_t stat_i,
  output pba_pkg::pba_cmd_t      cmd_o
);

  import pba_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DECODE = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_REL_WR = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat_i.is_release) begin
          if (stat_i.rel_oor) begin
            cmd_o.set_range = 1'b1;
            state_d         = ST_DONE;
          end else begin
            cmd_o.rel_read = 1'b1;
            state_d        = ST_REL_WR;
          end
        end else if (stat_i.range_empty) begin
          cmd_o.set_full = 1'b1;
          state_d        = ST_DONE;
        end else begin
          cmd_o.scan_first = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat_i.found) begin
          cmd_o.scan_commit = 1'b1;
          state_d           = ST_DONE;
        end else if (stat_i.chk_last) begin
          cmd_o.set_full = 1'b1;
          state_d        = ST_DONE;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      ST_REL_WR: begin
        cmd_o.rel_write = 1'b1;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pba_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pba_datapath #(
  parameter int PID_SPACE = 4096,
  parameter int WORDS     = 64,
  parameter int AW        = 6
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [pba_pkg::ID_W-1:0] cfg_wdata_i,
  input  wire pba_pkg::in_item_t   in_item_i,
  output pba_pkg::out_item_t       out_item_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire pba_pkg::pba_cmd_t   cmd_i,
  output pba_pkg::pba_stat_t       stat_o
);

  import pba_pkg::*;

  localparam logic [CNT_W-1:0] SPACE_CNT =
      (PID_SPACE > (1 << ID_W)) ? CNT_W'(1 << ID_W) : CNT_W'(PID_SPACE);
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

  logic [ID_W-1:0]  min_q, min_d, max_q, max_d;
  logic             mode_q, mode_d;
  logic [ID_W-1:0]  pid_q, pid_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [AW-1:0]    chk_q, chk_d;
  logic [AW-1:0]    clr_q, clr_d;
  out_item_t        res_q, res_d;
  out_item_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic [CNT_W-1:0]  cnt_now;
  logic [CNT_W-1:0]  span;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  rel_off;
  logic [ID_W-1:0]   rel_idx;
  logic [AW-1:0]     rel_word;
  logic [BIT_W-1:0]  rel_bit;
  logic [AW-1:0]     last_w;
  logic [BIT_W-1:0]  last_bit;
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] valid_mask;
  ffs_t              hit;
  logic [AW+BIT_W-1:0] grant_idx;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata;

  always_comb begin
    span = {1'b0, max_q} - {1'b0, min_q} + CNT_W'(1);
    if (min_q > max_q) begin
      cnt_now = '0;
    end else if (span > SPACE_CNT) begin
      cnt_now = SPACE_CNT;
    end else begin
      cnt_now = span;
    end
  end

  assign cnt_m1   = cnt_q - CNT_W'(1);
  assign last_w   = AW'(cnt_m1[ID_W-1:BIT_W]);
  assign last_bit = cnt_m1[BIT_W-1:0];

  assign rel_off  = {1'b0, pid_q} - {1'b0, min_q};
  assign rel_idx  = rel_off[ID_W-1:0];
  assign rel_word = AW'(rel_idx[ID_W-1:BIT_W]);
  assign rel_bit  = rel_idx[BIT_W-1:0];

  always_comb begin
    if (chk_q == last_w) begin
      valid_mask = {WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - last_bit);
    end else begin
      valid_mask = {WORD_W{1'b1}};
    end
  end

  assign hit       = find_first_set(~rdata & valid_mask);
  assign grant_idx = {chk_q, hit.idx};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = chk_q;
    ram_wdata = rdata | ({{(WORD_W-1){1'b0}}, 1'b1} << hit.idx);
    if (cmd_i.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (cmd_i.rel_write) begin
      ram_we    = 1'b1;
      ram_waddr = rel_word;
      ram_wdata = rdata & ~({{(WORD_W-1){1'b0}}, 1'b1} << rel_bit);
    end else if (cmd_i.scan_commit) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    ram_re    = cmd_i.rel_read | cmd_i.scan_first | cmd_i.scan_next;
    ram_raddr = chk_q + AW'(1);
    if (cmd_i.rel_read) begin
      ram_raddr = rel_word;
    end else if (cmd_i.scan_first) begin
      ram_raddr = '0;
    end
  end

  pba_ram #(
    .WIDTH(WORD_W),
    .DEPTH(WORDS),
    .AW   (AW)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    min_d       = min_q;
    max_d       = max_q;
    mode_d      = mode_q;
    pid_d       = pid_q;
    cnt_d       = cnt_q;
    chk_d       = chk_q;
    clr_d       = clr_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (cfg_we_i) begin
      if (cfg_idx_i == CFG_MIN_PID) begin
        min_d = cfg_wdata_i;
      end else begin
        max_d = cfg_wdata_i;
      end
    end
    if (cmd_i.clr_step) begin
      clr_d = clr_q + AW'(1);
    end
    if (cmd_i.accept) begin
      mode_d             = in_item_i.mode;
      pid_d              = in_item_i.pid;
      cnt_d              = cnt_now;
      res_d.granted_pid  = '0;
      res_d.status       = STATUS_OK;
    end
    if (cmd_i.scan_first) begin
      chk_d = '0;
    end
    if (cmd_i.scan_next) begin
      chk_d = chk_q + AW'(1);
    end
    if (cmd_i.scan_commit) begin
      res_d.granted_pid = min_q + ID_W'(grant_idx);
    end
    if (cmd_i.set_full) begin
      res_d.status = STATUS_FULL;
    end
    if (cmd_i.set_range) begin
      res_d.status = STATUS_RANGE;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load_out) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q       <= MIN_PID_RESET;
      max_q       <= MAX_PID_RESET;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      min_q       <= min_d;
      max_q       <= max_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    pid_q  <= pid_d;
    cnt_q  <= cnt_d;
    chk_q  <= chk_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign stat_o.clr_last    = (clr_q == LAST_WORD);
  assign stat_o.is_release  = (mode_q == MODE_RELEASE);
  assign stat_o.rel_oor     = (pid_q < min_q) || (rel_off >= cnt_q);
  assign stat_o.range_empty = (cnt_q == '0);
  assign stat_o.found       = hit.found;
  assign stat_o.chk_last    = (chk_q == last_w);
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

  assign out_item_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/pid_bitmap_allocator_top.sv =====
// Allocate: words holding the range are read one per cycle from the bitmap RAM, from word
// 0 until a free id is found or the last word of the range has been checked.
// Release: a read-modify-write of one bitmap word; an out-of-range release writes none.
// One item is in work at a time; its result waits in an output register.
// After reset a clearing pass writes ceil(PID_SPACE/64) words before the first item is
// accepted; configuration writes are taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module pid_bitmap_allocator_top #(
  parameter int PID_SPACE = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic                     cfg_idx_i,
  input  wire logic [pba_pkg::ID_W-1:0] cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire pba_pkg::in_item_t        in_item_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output pba_pkg::out_item_t            out_item_o
);

  import pba_pkg::*;

  localparam int WORDS = (PID_SPACE + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  pba_cmd_t  cmd;
  pba_stat_t stat;

  pba_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  pba_datapath #(
    .PID_SPACE(PID_SPACE),
    .WORDS    (WORDS),
    .AW       (AW)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

endmodule

`default_nettype wire
